// ===== rtl/ramt_pkg.sv =====
package ramt_pkg;

    typedef enum logic [1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_FIND    = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_CHECK,
        S_DECIDE,
        S_ALLOC,
        S_UNLINK,
        S_OUT
    } fsm_t;

    localparam int STATUS_BITS = 2;
    localparam int SLOT_BITS   = 5;
    localparam int RCOUNT_BITS = 16;

endpackage

// ===== rtl/refcounted_address_monitor_table.sv =====
// Channel | Direction | tdata (low bit first)                | tuser
// s_axis  | in        | mode[1:0], address[ADDR_BITS+1:2]    | -
// m_axis  | out       | status[1:0], slot[6:2], ref_count    | -
//
// An operation reads the bucket head, reads the entry, compares and decides;
// each chain entry passed before the match or the end of the chain adds another
// entry read and compare, and an allocation or an unlink adds a write step.
// The next transaction is accepted only once the block is back in idle. A new
// transaction may be accepted while a result waits; the walk then holds at its
// last compare until the output register is free. Reset (rst_n low) starts a pass that
// empties all buckets, clears all counts and rebuilds the free list in entry order;
// no transaction is accepted until that clearing pass has covered every entry.
module refcounted_address_monitor_table #(
    parameter int ENTRIES_LOG2 = 5,
    parameter int ADDR_BITS    = 32,
    parameter int COUNT_BITS   = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // mode (2 bits), address (ADDR_BITS), zero fill to bytes
    input  logic [((2 + ADDR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status (2), slot (5), ref_count (16), zero fill
    output logic [23:0] m_axis_tdata
);
    localparam int ENTRIES = 1 << ENTRIES_LOG2;
    localparam int PW      = ENTRIES_LOG2 + 1;
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // Entry memory: next pointer, address, count in one word.
    localparam int EW = PW + ADDR_BITS + COUNT_BITS;
    logic [EW-1:0] ent_mem [ENTRIES];
    logic [PW-1:0] head_mem [ENTRIES];
    logic [EW-1:0] ent_q;
    logic [PW-1:0] head_q;

    logic ent_we, head_we;
    logic [ENTRIES_LOG2-1:0] ent_waddr, ent_raddr, head_waddr, head_raddr;
    logic [EW-1:0] ent_wdata;
    logic [PW-1:0] head_wdata;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_q <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[head_raddr];
    end

    ramt_pkg::fsm_t state_reg, state_next;
    logic init_reg;
    logic [PW-1:0] clr_reg;
    logic [1:0] mode_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ENTRIES_LOG2-1:0] bkt_reg;
    logic [PW-1:0] cur_reg, prev_reg, free_head_reg, steps_reg;
    logic [PW-1:0] free_total_reg;
    logic [EW-1:0] cur_q_reg;
    logic [EW-1:0] prev_word_reg;
    logic out_valid_reg;
    logic [23:0] out_reg;

    wire [PW-1:0] q_next = ent_q[EW-1 -: PW];
    wire [ADDR_BITS-1:0] q_addr = ent_q[COUNT_BITS +: ADDR_BITS];
    wire [COUNT_BITS-1:0] q_cnt = ent_q[COUNT_BITS-1:0];
    wire [PW-1:0] c_next = cur_q_reg[EW-1 -: PW];
    wire [COUNT_BITS-1:0] c_cnt = cur_q_reg[COUNT_BITS-1:0];
    wire [ADDR_BITS-1:0] in_addr = s_axis_tdata[2 +: ADDR_BITS];
    wire [ENTRIES_LOG2-1:0] in_bkt = ENTRIES_LOG2'((in_addr >> 2) ^ (in_addr >> 10));
    wire found = (cur_reg != NIL);
    wire accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ramt_pkg::S_IDLE) && !init_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    function automatic logic [23:0] pack_out(input logic [1:0] st,
                                             input logic [PW-1:0] sl,
                                             input logic [COUNT_BITS-1:0] c);
        logic [23:0] r;
        r = '0;
        r[1:0] = st;
        r[6:2] = 5'(sl);
        r[22:7] = 16'(c);
        return r;
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ramt_pkg::S_IDLE:   if (accept) state_next = ramt_pkg::S_HEAD;
            ramt_pkg::S_HEAD:   state_next = ramt_pkg::S_WALK;
            ramt_pkg::S_WALK:   state_next = ramt_pkg::S_CHECK;
            ramt_pkg::S_CHECK:
            begin
                if (cur_reg == NIL || q_addr == addr_reg || steps_reg == PW'(ENTRIES))
                begin
                    // The result register must be free before any state is changed.
                    if (!out_valid_reg || m_axis_tready)
                        state_next = ramt_pkg::S_DECIDE;
                end
                else
                    state_next = ramt_pkg::S_WALK;
            end
            ramt_pkg::S_DECIDE:
            begin
                if (mode_reg == ramt_pkg::MODE_ACQUIRE && !found && free_total_reg != '0)
                    state_next = ramt_pkg::S_ALLOC;
                else if (mode_reg == ramt_pkg::MODE_RELEASE && found
                         && c_cnt == COUNT_BITS'(1))
                    state_next = ramt_pkg::S_UNLINK;
                else
                    state_next = ramt_pkg::S_IDLE;
            end
            ramt_pkg::S_ALLOC:  state_next = ramt_pkg::S_IDLE;
            ramt_pkg::S_UNLINK: state_next = ramt_pkg::S_IDLE;
            default:            state_next = ramt_pkg::S_IDLE;
        endcase
    end

    // Memory port control
    always_comb
    begin
        ent_we = 1'b0; head_we = 1'b0;
        ent_waddr = cur_reg[ENTRIES_LOG2-1:0];
        ent_wdata = '0;
        ent_raddr = cur_reg[ENTRIES_LOG2-1:0];
        head_waddr = bkt_reg; head_wdata = '0;
        head_raddr = (state_reg == ramt_pkg::S_IDLE) ? in_bkt : bkt_reg;
        if (init_reg)
        begin
            ent_we = 1'b1; head_we = 1'b1;
            ent_waddr = clr_reg[ENTRIES_LOG2-1:0];
            ent_wdata = {clr_reg + PW'(1), {ADDR_BITS{1'b0}}, {COUNT_BITS{1'b0}}};
            head_waddr = clr_reg[ENTRIES_LOG2-1:0];
            head_wdata = NIL;
        end
        else
        begin
            case (state_reg)
                ramt_pkg::S_ALLOC:
                begin
                    // free list head is read at DECIDE into ent_q
                    ent_we = 1'b1; head_we = 1'b1;
                    ent_waddr = free_head_reg[ENTRIES_LOG2-1:0];
                    ent_wdata = {head_q, addr_reg, COUNT_BITS'(1)};
                    head_wdata = free_head_reg;
                end
                ramt_pkg::S_DECIDE:
                begin
                    ent_raddr = free_head_reg[ENTRIES_LOG2-1:0];
                    if (mode_reg == ramt_pkg::MODE_ACQUIRE && found && c_cnt != CMAX)
                    begin
                        ent_we = 1'b1;
                        ent_wdata = {c_next, addr_reg, c_cnt + COUNT_BITS'(1)};
                    end
                    if (mode_reg == ramt_pkg::MODE_RELEASE && found)
                    begin
                        ent_we = 1'b1;
                        ent_wdata = {(c_cnt == COUNT_BITS'(1)) ? free_head_reg : c_next,
                                     addr_reg, c_cnt - COUNT_BITS'(1)};
                    end
                end
                ramt_pkg::S_UNLINK:
                begin
                    if (prev_reg == NIL)
                    begin
                        head_we = 1'b1;
                        head_wdata = c_next;
                    end
                    else
                    begin
                        // predecessor word was kept when the walk passed it
                        ent_we = 1'b1;
                        ent_waddr = prev_reg[ENTRIES_LOG2-1:0];
                        ent_wdata = {c_next, prev_word_reg[EW-PW-1:0]};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ramt_pkg::S_IDLE;
            init_reg <= 1'b1;
            clr_reg <= '0;
            free_head_reg <= '0;
            free_total_reg <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (init_reg)
            begin
                clr_reg <= clr_reg + PW'(1);
                if (clr_reg == PW'(ENTRIES - 1))
                    init_reg <= 1'b0;
            end
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ramt_pkg::S_DECIDE:
                begin
                    if (state_next == ramt_pkg::S_IDLE)
                        out_valid_reg <= 1'b1;
                    if (state_next == ramt_pkg::S_UNLINK)
                    begin
                        free_head_reg <= cur_reg;
                        free_total_reg <= free_total_reg + PW'(1);
                    end
                end
                ramt_pkg::S_ALLOC:
                begin
                    free_head_reg <= q_next;
                    free_total_reg <= free_total_reg - PW'(1);
                    out_valid_reg <= 1'b1;
                end
                ramt_pkg::S_UNLINK: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ramt_pkg::S_IDLE:
            begin
                mode_reg <= s_axis_tdata[1:0];
                addr_reg <= in_addr;
                bkt_reg <= in_bkt;
                prev_reg <= NIL;
                steps_reg <= '0;
            end
            ramt_pkg::S_HEAD: cur_reg <= head_q;
            ramt_pkg::S_CHECK:
            begin
                cur_q_reg <= ent_q;
                if (cur_reg != NIL && q_addr != addr_reg)
                begin
                    if (steps_reg == PW'(ENTRIES))
                        cur_reg <= NIL;
                    else
                    begin
                        prev_reg <= cur_reg;
                        prev_word_reg <= ent_q;
                        cur_reg <= q_next;
                    end
                    steps_reg <= steps_reg + PW'(1);
                end
            end
            ramt_pkg::S_DECIDE:
            begin
                if (mode_reg == ramt_pkg::MODE_ACQUIRE)
                begin
                    if (found)
                        out_reg <= (c_cnt == CMAX)
                            ? pack_out(ramt_pkg::ST_OVERFLOW, cur_reg, c_cnt)
                            : pack_out(ramt_pkg::ST_OK, cur_reg, c_cnt + COUNT_BITS'(1));
                    else if (free_total_reg == '0)
                        out_reg <= pack_out(ramt_pkg::ST_FULL, '0, '0);
                    else
                        out_reg <= pack_out(ramt_pkg::ST_OK, free_head_reg, COUNT_BITS'(1));
                end
                else if ((mode_reg == ramt_pkg::MODE_RELEASE ||
                          mode_reg == ramt_pkg::MODE_FIND) && found && c_cnt != '0)
                    out_reg <= pack_out(ramt_pkg::ST_OK, cur_reg,
                        (mode_reg == ramt_pkg::MODE_RELEASE) ? c_cnt - COUNT_BITS'(1) : c_cnt);
                else
                    out_reg <= pack_out(ramt_pkg::ST_NOT_FOUND, '0, '0);
            end
            default: ;
        endcase
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ramt_pkg::S_IDLE) |-> !s_axis_tready)
        else $error("accepted while busy");
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= NIL)
        else $error("free total out of range");
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) != ramt_pkg::S_IDLE)
        else $error("result without operation");

endmodule

// ===== dv/ramt_checker.sv =====
`timescale 1ns / 100ps

module ramt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_results
);

    localparam int NSLOT = 32;
    localparam int NIL = NSLOT;
    localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

    typedef struct packed {
        ramt_pkg::status_t status;
        logic [4:0]        slot;
        logic [15:0]       ref_count;
    } monitor_result_t;

    int          head_of_bucket [NSLOT];
    int          next_of_entry [NSLOT];
    logic [31:0] addr_of_entry [NSLOT];
    logic [15:0] count_of_entry [NSLOT];
    int          free_list_head;
    int          free_slot_count;

    monitor_result_t expected_results[$];

    assign pending_results = expected_results.size();

    function automatic monitor_result_t table_update(ramt_pkg::mode_t mode,
                                                     logic [31:0] addr);
        monitor_result_t r;
        logic [31:0] h;
        int bkt;
        int cur;
        int prev;
        int hit;
        int steps;
        h = (addr >> 2) ^ (addr >> 10);
        bkt = int'(h[4:0]);
        cur = head_of_bucket[bkt];
        prev = NIL;
        hit = NIL;
        steps = 0;
        while (steps < NSLOT && cur < NSLOT && hit == NIL)
        begin
            if (addr_of_entry[cur] == addr)
                hit = cur;
            else
            begin
                prev = cur;
                cur = next_of_entry[cur];
            end
            steps++;
        end
        r = '{ramt_pkg::ST_NOT_FOUND, 5'd0, 16'd0};
        case (mode)
            ramt_pkg::MODE_ACQUIRE:
            begin
                if (hit == NIL)
                begin
                    if (free_slot_count == 0 || free_list_head >= NSLOT)
                        return '{ramt_pkg::ST_FULL, 5'd0, 16'd0};
                    hit = free_list_head;
                    free_list_head = next_of_entry[hit];
                    free_slot_count--;
                    addr_of_entry[hit] = addr;
                    next_of_entry[hit] = head_of_bucket[bkt];
                    head_of_bucket[bkt] = hit;
                    count_of_entry[hit] = 16'd0;
                end
                if (count_of_entry[hit] >= COUNT_LIMIT)
                    return '{ramt_pkg::ST_OVERFLOW, 5'(hit), count_of_entry[hit]};
                count_of_entry[hit]++;
                r = '{ramt_pkg::ST_OK, 5'(hit), count_of_entry[hit]};
            end
            ramt_pkg::MODE_RELEASE:
            begin
                if (hit != NIL && count_of_entry[hit] != 16'd0)
                begin
                    count_of_entry[hit]--;
                    if (count_of_entry[hit] == 16'd0)
                    begin
                        if (prev == NIL)
                            head_of_bucket[bkt] = next_of_entry[hit];
                        else
                            next_of_entry[prev] = next_of_entry[hit];
                        next_of_entry[hit] = free_list_head;
                        free_list_head = hit;
                        free_slot_count++;
                    end
                    r = '{ramt_pkg::ST_OK, 5'(hit), count_of_entry[hit]};
                end
            end
            ramt_pkg::MODE_FIND:
            begin
                if (hit != NIL && count_of_entry[hit] != 16'd0)
                    r = '{ramt_pkg::ST_OK, 5'(hit), count_of_entry[hit]};
            end
            default:
                r = '{ramt_pkg::ST_NOT_FOUND, 5'd0, 16'd0};
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        monitor_result_t want;
        monitor_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                head_of_bucket[i] = NIL;
                next_of_entry[i] = i + 1;
                addr_of_entry[i] = '0;
                count_of_entry[i] = '0;
            end
            free_list_head = 0;
            free_slot_count = NSLOT;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{ramt_pkg::status_t'(m_axis_tdata[1:0]), m_axis_tdata[6:2],
                        m_axis_tdata[22:7]};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: actual %p", $realtime, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.slot != want.slot
                            || got.ref_count != want.ref_count)
                    begin
                        $display("%0t: mismatch: expected %p, actual %p",
                                 $realtime, want, got);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(
                    table_update(ramt_pkg::mode_t'(s_axis_tdata[1:0]), s_axis_tdata[33:2]));
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // mode, address, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // status, slot, ref_count, zero fill

    int fail_count;
    int pending_results;
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;
    bit hold_off;
    logic [31:0] addr_pool [16];

    refcounted_address_monitor_table u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    ramt_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count),
        .pending_results(pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off while the sender keeps going.
    always @(negedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles without any accepted transaction on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_op(ramt_pkg::mode_t mode, logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, addr, mode};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly acquire/release of a small pool so that chains grow and the table fills.
    task automatic random_ops(int n);
        ramt_pkg::mode_t m;
        logic [31:0] a;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            m = r < 45 ? ramt_pkg::MODE_ACQUIRE : r < 80 ? ramt_pkg::MODE_RELEASE
                : r < 97 ? ramt_pkg::MODE_FIND : ramt_pkg::MODE_UNUSED;
            a = ($urandom_range(9) == 0) ? $urandom() : addr_pool[$urandom_range(15)];
            if ($urandom_range(3) == 0)
                a = a ^ ($urandom_range(31) << 2);
            send_op(m, a);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 10;
        recv_idle_pct = 81;
        for (int i = 0; i < 16; i++)
            addr_pool[i] = $urandom();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: absent lookups, extremes, repeated acquire, full table, unused mode.
        send_op(ramt_pkg::MODE_FIND, 32'h0);
        send_op(ramt_pkg::MODE_RELEASE, 32'hFFFF_FFFF);
        send_op(ramt_pkg::MODE_ACQUIRE, 32'h0);
        send_op(ramt_pkg::MODE_ACQUIRE, 32'hFFFF_FFFF);
        send_op(ramt_pkg::MODE_ACQUIRE, 32'h0);
        send_op(ramt_pkg::MODE_FIND, 32'h0);
        send_op(ramt_pkg::MODE_RELEASE, 32'h0);
        send_op(ramt_pkg::MODE_RELEASE, 32'h0);
        send_op(ramt_pkg::MODE_FIND, 32'h0);
        send_op(ramt_pkg::MODE_UNUSED, 32'hFFFF_FFFF);
        // Same bucket: addresses that differ only in bits that cancel in the hash.
        send_op(ramt_pkg::MODE_ACQUIRE, 32'h0000_1004);
        send_op(ramt_pkg::MODE_ACQUIRE, 32'h0000_0014);
        send_op(ramt_pkg::MODE_RELEASE, 32'h0000_1004);
        for (int i = 0; i < 33; i++)
            send_op(ramt_pkg::MODE_ACQUIRE, 32'h5000_0000 + (i << 12));
        for (int i = 0; i < 33; i++)
            send_op(ramt_pkg::MODE_RELEASE, 32'h5000_0000 + (i << 12));
        send_op(ramt_pkg::MODE_RELEASE, 32'hFFFF_FFFF);
        send_op(ramt_pkg::MODE_RELEASE, 32'h0000_0014);

        random_ops(450);
        send_idle_pct = 81;
        recv_idle_pct = 10;
        random_ops(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            random_ops(100);
        join
        random_ops(350);
        s_axis_tvalid <= 1'b0;

        while (pending_results != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
